### src/assert_macros.svh
// Assertion macros for the sequencer RTL; clns_seq is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define CLNS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define CLNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/clns_pkg.sv
// Types, constants and the microcode program of the LCD nibble sequencer.
package clns_pkg;

    typedef enum logic [2:0] {
        ACT_DATA   = 3'd0,
        ACT_CMD    = 3'd1,
        ACT_CURSOR = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_INIT   = 3'd4
    } action_t;

    localparam int ROM_DEPTH = 29;
    localparam int PC_W      = $clog2(ROM_DEPTH);

    localparam logic [PC_W-1:0] ENTRY_DATA = PC_W'(0);
    localparam logic [PC_W-1:0] ENTRY_CMD  = PC_W'(4);
    localparam logic [PC_W-1:0] ENTRY_INIT = PC_W'(8);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_BACKLIGHT = 1'b0;

    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] RAW_INIT_BYTE = 8'h08;

    localparam logic [2:0] WAIT_STROBE = 3'd2;
    localparam logic [2:0] WAIT_NONE   = 3'd0;
    localparam logic [2:0] WAIT_INIT   = 3'd5;

    // One control word per output byte.
    typedef struct packed {
        logic       src_const;
        logic [7:0] const_byte;
        logic       rs;
        logic       lo_half;
        logic       en;
        logic [2:0] wait_ms;
        logic       last;
        logic       raw;
    } ctl_t;

    // Builds the control word for one of the four steps of an LCD byte.
    function automatic ctl_t nib_step(input logic is_const, input logic [7:0] cbyte,
                                      input logic rs, input logic [1:0] sub,
                                      input logic [2:0] tail, input logic ends);
        ctl_t w;
        w.src_const  = is_const;
        w.const_byte = cbyte;
        w.rs         = rs;
        w.lo_half    = sub[1];
        w.en         = ~sub[0];
        w.wait_ms    = sub[0] ? ((sub == 2'd3) ? tail : WAIT_NONE) : WAIT_STROBE;
        w.last       = ends && (sub == 2'd3);
        w.raw        = 1'b0;
        return w;
    endfunction

    function automatic ctl_t rom_word(input logic [PC_W-1:0] pc);
        ctl_t w;
        w = '0;
        case (pc)
            // Data byte from the operand register, RS set.
            PC_W'(0):  w = nib_step(1'b0, 8'h00, 1'b1, 2'd0, WAIT_NONE, 1'b1);
            PC_W'(1):  w = nib_step(1'b0, 8'h00, 1'b1, 2'd1, WAIT_NONE, 1'b1);
            PC_W'(2):  w = nib_step(1'b0, 8'h00, 1'b1, 2'd2, WAIT_NONE, 1'b1);
            PC_W'(3):  w = nib_step(1'b0, 8'h00, 1'b1, 2'd3, WAIT_NONE, 1'b1);
            // Command byte from the operand register, RS clear.
            PC_W'(4):  w = nib_step(1'b0, 8'h00, 1'b0, 2'd0, WAIT_NONE, 1'b1);
            PC_W'(5):  w = nib_step(1'b0, 8'h00, 1'b0, 2'd1, WAIT_NONE, 1'b1);
            PC_W'(6):  w = nib_step(1'b0, 8'h00, 1'b0, 2'd2, WAIT_NONE, 1'b1);
            PC_W'(7):  w = nib_step(1'b0, 8'h00, 1'b0, 2'd3, WAIT_NONE, 1'b1);
            // Init program.
            PC_W'(8):  w = nib_step(1'b1, 8'h33, 1'b0, 2'd0, WAIT_INIT, 1'b0);
            PC_W'(9):  w = nib_step(1'b1, 8'h33, 1'b0, 2'd1, WAIT_INIT, 1'b0);
            PC_W'(10): w = nib_step(1'b1, 8'h33, 1'b0, 2'd2, WAIT_INIT, 1'b0);
            PC_W'(11): w = nib_step(1'b1, 8'h33, 1'b0, 2'd3, WAIT_INIT, 1'b0);
            PC_W'(12): w = nib_step(1'b1, 8'h32, 1'b0, 2'd0, WAIT_INIT, 1'b0);
            PC_W'(13): w = nib_step(1'b1, 8'h32, 1'b0, 2'd1, WAIT_INIT, 1'b0);
            PC_W'(14): w = nib_step(1'b1, 8'h32, 1'b0, 2'd2, WAIT_INIT, 1'b0);
            PC_W'(15): w = nib_step(1'b1, 8'h32, 1'b0, 2'd3, WAIT_INIT, 1'b0);
            PC_W'(16): w = nib_step(1'b1, 8'h28, 1'b0, 2'd0, WAIT_INIT, 1'b0);
            PC_W'(17): w = nib_step(1'b1, 8'h28, 1'b0, 2'd1, WAIT_INIT, 1'b0);
            PC_W'(18): w = nib_step(1'b1, 8'h28, 1'b0, 2'd2, WAIT_INIT, 1'b0);
            PC_W'(19): w = nib_step(1'b1, 8'h28, 1'b0, 2'd3, WAIT_INIT, 1'b0);
            PC_W'(20): w = nib_step(1'b1, 8'h0C, 1'b0, 2'd0, WAIT_INIT, 1'b0);
            PC_W'(21): w = nib_step(1'b1, 8'h0C, 1'b0, 2'd1, WAIT_INIT, 1'b0);
            PC_W'(22): w = nib_step(1'b1, 8'h0C, 1'b0, 2'd2, WAIT_INIT, 1'b0);
            PC_W'(23): w = nib_step(1'b1, 8'h0C, 1'b0, 2'd3, WAIT_INIT, 1'b0);
            PC_W'(24): w = nib_step(1'b1, LCD_CLEAR, 1'b0, 2'd0, WAIT_NONE, 1'b0);
            PC_W'(25): w = nib_step(1'b1, LCD_CLEAR, 1'b0, 2'd1, WAIT_NONE, 1'b0);
            PC_W'(26): w = nib_step(1'b1, LCD_CLEAR, 1'b0, 2'd2, WAIT_NONE, 1'b0);
            PC_W'(27): w = nib_step(1'b1, LCD_CLEAR, 1'b0, 2'd3, WAIT_NONE, 1'b0);
            PC_W'(28):
            begin
                w.src_const  = 1'b1;
                w.const_byte = RAW_INIT_BYTE;
                w.wait_ms    = WAIT_INIT;
                w.last       = 1'b1;
                w.raw        = 1'b1;
            end
            default:
            begin
                // Unused addresses end the program.
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### src/clns_in_if.sv
// Request channel carrying one LCD action item.
interface clns_in_if;
    import clns_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [7:0]        value;
    logic signed [7:0] column;
    logic signed [7:0] row;

    modport source (output valid, output action, output value, output column,
                    output row, input ready);
    modport sink (input valid, input action, input value, input column,
                  input row, output ready);
endinterface

### src/clns_out_if.sv
// Result channel carrying one expander byte item.
interface clns_out_if;
    import clns_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] expander_byte;
    logic [2:0] wait_ms;
    logic       last;

    modport source (output valid, output expander_byte, output wait_ms, output last,
                    input ready);
    modport sink (input valid, input expander_byte, input wait_ms, input last,
                  output ready);
endinterface

### src/clns_seq.sv
// Step counter and microcode lookup of the nibble sequencer.
`include "assert_macros.svh"

module clns_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0]                   action,
    input  logic                         advance,
    output clns_pkg::ctl_t               ctl,
    output logic                         busy
);
    import clns_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] entry;
    logic            known;

    always_comb
    begin
        entry = ENTRY_DATA;
        known = 1'b1;
        case (action)
            ACT_DATA:                        entry = ENTRY_DATA;
            ACT_CMD, ACT_CURSOR, ACT_CLEAR:  entry = ENTRY_CMD;
            ACT_INIT:                        entry = ENTRY_INIT;
            default:                         known = 1'b0;
        endcase
    end

    assign ctl = rom_word(pc_reg);

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (advance)
        begin
            if (ctl.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
        // A new item may be taken on the final step of the previous one.
        if (start && known)
        begin
            busy_next = 1'b1;
            pc_next   = entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

    `CLNS_ASSERT_IMPLY(a_pc_in_rom, busy_reg, pc_reg < PC_W'(ROM_DEPTH), "pc outside program")
    `CLNS_ASSERT_NEXT(a_end_idle, advance && ctl.last && !start, !busy_reg,
                      "sequencer still busy after final step")
    `CLNS_ASSERT_NEXT(a_dispatch, start && known, busy_reg && pc_reg == $past(entry),
                      "dispatch did not load entry point")
endmodule

### src/char_lcd_nibble_sequencer_core.sv
// Top level of the character-LCD nibble sequencer for an I2C port expander.
// Each accepted item is one LCD action; the block emits one expander byte item per
// cycle from a microcoded step counter into an output register, so throughput is
// one result byte per clock while the sink takes them. Data, command, set cursor and
// clear produce 4 bytes (items run back to back, since the next item is taken
// on the final step of the current one); init produces 21 bytes.
// Unknown actions are accepted and produce nothing. Backlight (register 0, byte
// address 0, reset 1) sets bit 3 of every byte except the raw 0x08 that ends init.
module char_lcd_nibble_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    clns_in_if.sink                             in_ch,
    clns_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clns_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [clns_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [clns_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import clns_pkg::*;

    logic       backlight_reg;
    logic       backlight_next;
    logic [7:0] operand_reg;
    logic [7:0] operand_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [2:0] wait_reg;
    logic [2:0] wait_next;
    logic       last_reg;
    logic       last_next;

    ctl_t       ctl;
    logic       busy;
    logic       advance;
    logic       start;
    logic [3:0] col_clamped;
    logic       row_clamped;
    logic [7:0] src_byte;
    logic [3:0] nib;

    // Configuration port.
    assign pready = 1'b1;
    always_comb
    begin
        backlight_next = backlight_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_BACKLIGHT)
        begin
            backlight_next = pwdata[0];
        end
    end
    assign prdata = (paddr[2] == REG_BACKLIGHT) ? {{(CFG_DATA_W-1){1'b0}}, backlight_reg}
                                                : '0;

    // Handshake.
    assign advance     = busy && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !busy || (advance && ctl.last);
    assign start       = in_ch.valid && in_ch.ready;

    clns_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .action  (in_ch.action),
        .advance (advance),
        .ctl     (ctl),
        .busy    (busy)
    );

    // Operand byte for the data and command programs.
    always_comb
    begin
        if (in_ch.column < 0)
        begin
            col_clamped = 4'd0;
        end
        else if (in_ch.column > 8'sd15)
        begin
            col_clamped = 4'd15;
        end
        else
        begin
            col_clamped = in_ch.column[3:0];
        end
        row_clamped = (in_ch.row > 8'sd0);

        operand_next = operand_reg;
        if (start)
        begin
            case (in_ch.action)
                ACT_DATA, ACT_CMD: operand_next = in_ch.value;
                ACT_CURSOR:        operand_next = LCD_SET_DDRAM
                                                  | {1'b0, row_clamped, 2'b00, col_clamped};
                ACT_CLEAR:         operand_next = LCD_CLEAR;
                default:           operand_next = operand_reg;
            endcase
        end
    end

    // Byte formatter and output register.
    assign src_byte = ctl.src_const ? ctl.const_byte : operand_reg;
    assign nib      = ctl.lo_half ? src_byte[3:0] : src_byte[7:4];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        wait_next      = wait_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            byte_next      = ctl.raw ? ctl.const_byte
                                     : {nib, backlight_reg, ctl.en, 1'b0, ctl.rs};
            wait_next      = ctl.wait_ms;
            last_next      = ctl.last;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            backlight_reg <= backlight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        operand_reg <= operand_next;
        byte_reg    <= byte_next;
        wait_reg    <= wait_next;
        last_reg    <= last_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.expander_byte = byte_reg;
    assign out_ch.wait_ms       = wait_reg;
    assign out_ch.last          = last_reg;
endmodule

### tb/lcd_byte_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts and checks the expander byte stream of the LCD nibble sequencer.
module lcd_byte_checker
    import clns_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    clns_in_if                    req_ch,
    clns_out_if                   byte_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    outstanding,
    output int                    requests_seen,
    output int                    bytes_checked
);

    typedef struct packed {
        logic [7:0] expander_byte;
        logic [2:0] wait_ms;
        logic       last;
    } lcd_out_t;

    localparam logic [CFG_ADDR_W-1:0] BACKLIGHT_ADDR = {REG_BACKLIGHT, 2'b00};

    localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
    localparam logic [7:0] ENABLE_BIT    = 8'h04;
    localparam logic [7:0] RS_BIT        = 8'h01;
    localparam logic [7:0] ROW_STRIDE    = 8'h40;

    localparam logic [7:0] FUNC_SET_8BIT_A = 8'h33;
    localparam logic [7:0] FUNC_SET_8BIT_B = 8'h32;
    localparam logic [7:0] FUNC_SET_4BIT   = 8'h28;
    localparam logic [7:0] DISPLAY_ON      = 8'h0C;

    localparam int MAX_COLUMN = 15;
    localparam int MAX_ROW    = 1;

    lcd_out_t expected_bytes[$];
    lcd_out_t want;
    logic     backlight;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] wanted);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got,
                 wanted);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic [2:0] wait_ms,
                             input logic ends);
        lcd_out_t entry;
        entry.expander_byte = backlight ? (b | BACKLIGHT_BIT) : (b & ~BACKLIGHT_BIT);
        entry.wait_ms       = wait_ms;
        entry.last          = ends;
        expected_bytes.push_back(entry);
    endtask

    // One LCD byte goes out as two nibbles, each strobed with enable high then low.
    task automatic push_lcd_byte(input logic [7:0] b, input logic rs, input logic [2:0] tail,
                                 input logic ends);
        logic [7:0] ctl;
        logic [7:0] hi;
        logic [7:0] lo;
        ctl = ENABLE_BIT | (rs ? RS_BIT : 8'h00);
        hi  = (b & 8'hF0) | ctl;
        lo  = {b[3:0], 4'h0} | ctl;
        push_byte(hi, WAIT_STROBE, 1'b0);
        push_byte(hi & ~ENABLE_BIT, WAIT_NONE, 1'b0);
        push_byte(lo, WAIT_STROBE, 1'b0);
        push_byte(lo & ~ENABLE_BIT, tail, ends);
    endtask

    task automatic predict_request(input logic [2:0] act, input logic [7:0] val,
                                   input logic signed [7:0] col_in,
                                   input logic signed [7:0] row_in);
        int       col;
        int       row;
        lcd_out_t raw_entry;
        col = col_in;
        row = row_in;
        case (act)
            ACT_DATA:   push_lcd_byte(val, 1'b1, WAIT_NONE, 1'b1);
            ACT_CMD:    push_lcd_byte(val, 1'b0, WAIT_NONE, 1'b1);
            ACT_CURSOR:
            begin
                if (col < 0) col = 0;
                if (col > MAX_COLUMN) col = MAX_COLUMN;
                if (row < 0) row = 0;
                if (row > MAX_ROW) row = MAX_ROW;
                push_lcd_byte(LCD_SET_DDRAM + 8'(ROW_STRIDE * row) + 8'(col), 1'b0,
                              WAIT_NONE, 1'b1);
            end
            ACT_CLEAR:  push_lcd_byte(LCD_CLEAR, 1'b0, WAIT_NONE, 1'b1);
            ACT_INIT:
            begin
                push_lcd_byte(FUNC_SET_8BIT_A, 1'b0, WAIT_INIT, 1'b0);
                push_lcd_byte(FUNC_SET_8BIT_B, 1'b0, WAIT_INIT, 1'b0);
                push_lcd_byte(FUNC_SET_4BIT, 1'b0, WAIT_INIT, 1'b0);
                push_lcd_byte(DISPLAY_ON, 1'b0, WAIT_INIT, 1'b0);
                push_lcd_byte(LCD_CLEAR, 1'b0, WAIT_NONE, 1'b0);
                // The closing byte of init ignores the backlight setting.
                raw_entry.expander_byte = RAW_INIT_BYTE;
                raw_entry.wait_ms       = WAIT_INIT;
                raw_entry.last          = 1'b1;
                expected_bytes.push_back(raw_entry);
            end
            default:
            begin
                // Unknown actions produce nothing.
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight = 1'b1;
            expected_bytes.delete();
            mismatches    = 0;
            outstanding   = 0;
            requests_seen = 0;
            bytes_checked = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte with nothing pending", byte_ch.expander_byte,
                                    8'h00);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (byte_ch.expander_byte !== want.expander_byte)
                        report_mismatch("expander_byte", byte_ch.expander_byte,
                                        want.expander_byte);
                    if (byte_ch.wait_ms !== want.wait_ms)
                        report_mismatch("wait_ms", 8'(byte_ch.wait_ms), 8'(want.wait_ms));
                    if (byte_ch.last !== want.last)
                        report_mismatch("last", 8'(byte_ch.last), 8'(want.last));
                end
            end

            if (psel && penable && !pwrite && pready && paddr == BACKLIGHT_ADDR
                && prdata !== CFG_DATA_W'(backlight))
                report_mismatch("backlight readback", prdata[7:0], 8'(backlight));

            if (req_ch.valid && req_ch.ready)
            begin
                requests_seen++;
                predict_request(req_ch.action, req_ch.value, req_ch.column, req_ch.row);
            end

            if (psel && penable && pwrite && pready && paddr == BACKLIGHT_ADDR)
                backlight = pwdata[0];

            outstanding = expected_bytes.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the LCD sequencer testbench: clock, reset, request and register stimulus, verdict.
module testbench;
    import clns_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 32;
    localparam int RESET_CYCLES    = 5;
    localparam int NUM_PHASES      = 4;
    localparam int ITEMS_PER_PHASE = 62;

    localparam logic [CFG_ADDR_W-1:0] BACKLIGHT_ADDR = {REG_BACKLIGHT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

    localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count = 0;
    int mismatches;
    int outstanding;
    int requests_seen;
    int bytes_checked;

    clns_in_if  req_ch();
    clns_out_if byte_ch();

    char_lcd_nibble_sequencer_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (byte_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lcd_byte_checker byte_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_ch        (req_ch),
        .byte_ch       (byte_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .requests_seen (requests_seen),
        .bytes_checked (bytes_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d bytes pending.", cycle_count,
                     outstanding);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        byte_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Called and returns at a falling edge; valid is assigned once per step.
    task automatic send_request(input logic [2:0] act, input logic [7:0] val,
                                input logic signed [7:0] col, input logic signed [7:0] row);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid  <= 1'b0;
            req_ch.action <= 3'($urandom);
            req_ch.value  <= 8'($urandom);
            req_ch.column <= 8'($urandom);
            req_ch.row    <= 8'($urandom);
            @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        req_ch.column <= col;
        req_ch.row    <= row;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [2:0]        act;
        logic signed [7:0] col;
        logic signed [7:0] row;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 35)
            act = ACT_DATA;
        else if (pick < 55)
            act = ACT_CMD;
        else if (pick < 75)
            act = ACT_CURSOR;
        else if (pick < 83)
            act = ACT_CLEAR;
        else if (pick < 91)
            act = ACT_INIT;
        else
            act = 3'($urandom_range(ACT_UNKNOWN_HI, ACT_UNKNOWN_LO));
        // Half the cursor positions sit around the clamp limits.
        if ($urandom_range(1))
        begin
            col = 8'($urandom);
            row = 8'($urandom);
        end
        else
        begin
            col = 8'($urandom_range(18) - 2);
            row = 8'($urandom_range(4) - 2);
        end
        send_request(act, 8'($urandom), col, row);
    endtask

    task automatic register_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                                   input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // An unknown action leaves no expectation, so give the block time to finish.
    // The last request item was already taken, so valid drops before waiting.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_DATA;
        req_ch.value       = 8'h00;
        req_ch.column      = 8'sh00;
        req_ch.row         = 8'sh00;
        byte_ch.ready      = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        register_access(1'b0, BACKLIGHT_ADDR, '0);

        // Directed requests with the backlight at its reset value.
        send_request(ACT_DATA, 8'h00, 8'sh00, 8'sh00);
        send_request(ACT_DATA, 8'hFF, 8'sh7F, -8'sd128);
        send_request(ACT_CMD, 8'h00, -8'sd1, 8'sh7F);
        send_request(ACT_CMD, 8'hFF, 8'sh00, 8'sh00);
        send_request(ACT_CURSOR, 8'hFF, -8'sd128, -8'sd128);
        send_request(ACT_CURSOR, 8'h00, 8'sh7F, 8'sh7F);
        send_request(ACT_CURSOR, 8'h5A, 8'sh00, 8'sh00);
        send_request(ACT_CURSOR, 8'h00, 8'sd15, 8'sd1);
        send_request(ACT_CURSOR, 8'h00, 8'sd16, 8'sd2);
        send_request(ACT_CURSOR, 8'h00, -8'sd1, -8'sd1);
        send_request(ACT_CURSOR, 8'h00, 8'sd7, 8'sd0);
        send_request(ACT_CLEAR, 8'hFF, 8'sh7F, 8'sh7F);
        send_request(ACT_INIT, 8'hFF, 8'sd5, 8'sd1);
        send_request(ACT_UNKNOWN_LO, 8'hFF, 8'sh7F, 8'sh7F);
        send_request(3'd6, 8'h00, -8'sd128, -8'sd128);
        send_request(ACT_UNKNOWN_HI, 8'hA5, 8'sd3, 8'sd1);
        send_request(ACT_DATA, 8'hA5, 8'sd0, 8'sd0);
        wait_until_drained();

        // Backlight off; the spare address must not disturb it.
        register_access(1'b1, BACKLIGHT_ADDR, 32'hFFFF_FFFE);
        register_access(1'b1, SPARE_REG_ADDR, 32'hFFFF_FFFF);
        register_access(1'b0, BACKLIGHT_ADDR, '0);
        send_request(ACT_INIT, 8'h00, 8'sd0, 8'sd0);
        send_request(ACT_DATA, 8'h3C, 8'sd0, 8'sd0);
        send_request(ACT_CURSOR, 8'h00, 8'sd3, 8'sd1);
        send_request(ACT_CLEAR, 8'h00, 8'sd0, 8'sd0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_until_drained();
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 67;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 67;
                end
                default:
                begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            register_access(1'b1, BACKLIGHT_ADDR, {31'($urandom), ~phase[0]});
            register_access(1'b0, BACKLIGHT_ADDR, '0);
            repeat (ITEMS_PER_PHASE) send_random_request();
        end
        wait_until_drained();

        $display("Ran %0d LCD requests: directed cases, then four pacing phases with the",
                 requests_seen);
        $display("backlight toggled; %0d expander bytes compared.", bytes_checked);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
